### design/hiac_pkg.sv
// ----------------------------------------------------------------------------
// hiac_pkg
// shared item type, constants and a helper function for the hidden image alpha
// composite block
// ----------------------------------------------------------------------------
package hiac_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned HALF_W      = PIX_W - 1;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned NUM_W       = 15;
    localparam int unsigned DIV_STAGES  = PIX_W;

    localparam logic [16:0] RECIP_10    = 17'd52429;
    localparam logic [PIX_W:0] ALPHA_OFS = 9'd127;

    // one classified pixel pair on its way to the divider
    typedef struct packed {
        logic [HALF_W-1:0] under_half;
        logic [PIX_W-1:0]  alpha;
        logic              frame_end;
    } item_t;

    // floor(n / 10) for n below 1531, reciprocal multiply
    function automatic logic [PIX_W-1:0] div10(input logic [10:0] n);
        logic [27:0] p;
        p = {17'd0, n} * {11'd0, RECIP_10};
        return p[26:19];
    endfunction

endpackage

### design/hiac_front.sv
// ----------------------------------------------------------------------------
// hiac_front
// accepts pixel pairs, forms the two greys and the composite alpha
// ----------------------------------------------------------------------------
module hiac_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            above_blue,
    input  logic [7:0]            above_green,
    input  logic [7:0]            above_red,
    input  logic [7:0]            under_blue,
    input  logic [7:0]            under_green,
    input  logic [7:0]            under_red,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hiac_pkg::item_t       out_item
);

    // stage 1: per channel tenths
    logic       v1_reg;
    logic [7:0] ab_reg, ag_reg, ar_reg, ub_reg, ug_reg, ur_reg;
    logic       fe1_reg;
    // stage 2: classified item
    logic            v2_reg;
    hiac_pkg::item_t item_reg;
    hiac_pkg::item_t item_next;

    logic rdy1, rdy2;
    logic [7:0] grey_a, grey_u;
    logic [8:0] alpha_w;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        grey_a  = ab_reg + ag_reg + ar_reg;
        grey_u  = ub_reg + ug_reg + ur_reg;
        alpha_w = {2'd0, grey_u[7:1]} + hiac_pkg::ALPHA_OFS - {2'd0, grey_a[7:1]};
        item_next.under_half = grey_u[7:1];
        item_next.alpha      = alpha_w[7:0];
        item_next.frame_end  = fe1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            ab_reg  <= hiac_pkg::div10({3'd0, above_blue});
            ag_reg  <= hiac_pkg::div10({1'b0, above_green, 2'b00} + {2'd0, above_green, 1'b0});
            ar_reg  <= hiac_pkg::div10({2'd0, above_red, 1'b0} + {3'd0, above_red});
            ub_reg  <= hiac_pkg::div10({3'd0, under_blue});
            ug_reg  <= hiac_pkg::div10({1'b0, under_green, 2'b00} + {2'd0, under_green, 1'b0});
            ur_reg  <= hiac_pkg::div10({2'd0, under_red, 1'b0} + {3'd0, under_red});
            fe1_reg <= frame_end;
        end
        if (rdy2 && v1_reg) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

### design/hiac_queue.sv
// ----------------------------------------------------------------------------
// hiac_queue
// short item queue between the front and the divider
// ----------------------------------------------------------------------------
module hiac_queue #(
    parameter int unsigned DEPTH = hiac_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  hiac_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output hiac_pkg::item_t out_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    hiac_pkg::item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign in_ready  = count_reg != FULL;
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= bump(wptr_reg);
            end
            if (pop) begin
                rptr_reg <= bump(rptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

endmodule

### design/hiac_back.sv
// ----------------------------------------------------------------------------
// hiac_back
// pipelined restoring divider, one quotient bit per stage, grey = u*255/alpha
// ----------------------------------------------------------------------------
module hiac_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  hiac_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_grey,
    output logic [7:0]      out_alpha,
    output logic            out_frame_end
);

    localparam int unsigned NS    = hiac_pkg::DIV_STAGES;
    localparam int unsigned NW    = hiac_pkg::NUM_W;
    localparam int unsigned PW    = hiac_pkg::PIX_W;

    logic          vld_reg [NS];
    logic [NW-1:0] rem_reg [NS];
    logic [PW-1:0] den_reg [NS];
    logic [PW-1:0] quo_reg [NS];
    logic          fe_reg  [NS];

    logic          rdy     [NS+1];
    logic [NW-1:0] rem_in  [NS];
    logic [PW-1:0] den_in  [NS];
    logic [PW-1:0] quo_in  [NS];
    logic          fe_in   [NS];
    logic          vld_in  [NS];
    logic [NW-1:0] rem_out [NS];
    logic [PW-1:0] quo_out [NS];

    logic [NW-1:0] numer;

    assign numer = {in_item.under_half, 8'd0} - {8'd0, in_item.under_half};

    always_comb begin
        rdy[NS] = out_ready;
        for (int j = NS - 1; j >= 0; j--) begin
            rdy[j] = !vld_reg[j] || rdy[j+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb begin
        logic [NW:0] trial;
        for (int j = 0; j < NS; j++) begin
            if (j == 0) begin
                vld_in[j] = in_valid;
                rem_in[j] = numer;
                den_in[j] = in_item.alpha;
                quo_in[j] = '0;
                fe_in[j]  = in_item.frame_end;
            end else begin
                vld_in[j] = vld_reg[j-1];
                rem_in[j] = rem_reg[j-1];
                den_in[j] = den_reg[j-1];
                quo_in[j] = quo_reg[j-1];
                fe_in[j]  = fe_reg[j-1];
            end
            trial      = {{(NW + 1 - PW){1'b0}}, den_in[j]} << (NS - 1 - j);
            rem_out[j] = rem_in[j];
            quo_out[j] = quo_in[j];
            if ({1'b0, rem_in[j]} >= trial) begin
                rem_out[j] = rem_in[j] - trial[NW-1:0];
                quo_out[j][NS-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NS; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else begin
            for (int j = 0; j < NS; j++) begin
                if (rdy[j]) begin
                    vld_reg[j] <= vld_in[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < NS; j++) begin
            if (rdy[j] && vld_in[j]) begin
                rem_reg[j] <= rem_out[j];
                den_reg[j] <= den_in[j];
                quo_reg[j] <= quo_out[j];
                fe_reg[j]  <= fe_in[j];
            end
        end
    end

    // zero opacity gives zero grey
    assign out_valid     = vld_reg[NS-1];
    assign out_grey      = (den_reg[NS-1] == '0) ? '0 : quo_reg[NS-1];
    assign out_alpha     = den_reg[NS-1];
    assign out_frame_end = fe_reg[NS-1];

endmodule

### design/hidden_image_alpha_compose.sv
// ----------------------------------------------------------------------------
// hidden_image_alpha_compose
// grey and alpha of a composite pixel from a surface and a hidden pixel
//
//   channel   direction   handshake          payload
//   s_        in          s_valid/s_ready    above_*, under_* bgr, frame_end
//   m_        out         m_valid/m_ready    out_grey, out_alpha, out_frame_end
//
// one pixel pair per clock sustained while m_ready is high; stages: 2 front, queue, 8 divider
// the divider resolves one quotient bit per stage over 8 stages
// aresetn is synchronous, active low, and empties all stages and the queue
// a stalled m_ready backs up through divider, queue and front in turn
// ----------------------------------------------------------------------------
module hidden_image_alpha_compose #(
    parameter int unsigned QUEUE_DEPTH = hiac_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_above_blue,
    input  logic [7:0] s_above_green,
    input  logic [7:0] s_above_red,
    input  logic [7:0] s_under_blue,
    input  logic [7:0] s_under_green,
    input  logic [7:0] s_under_red,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_grey,
    output logic [7:0] m_out_alpha,
    output logic       m_out_frame_end
);

    logic            f_valid, f_ready;
    hiac_pkg::item_t f_item;
    logic            q_valid, q_ready;
    hiac_pkg::item_t q_item;

    hiac_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .above_blue  (s_above_blue),
        .above_green (s_above_green),
        .above_red   (s_above_red),
        .under_blue  (s_under_blue),
        .under_green (s_under_green),
        .under_red   (s_under_red),
        .frame_end   (s_frame_end),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_item    (f_item)
    );

    hiac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    hiac_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_grey      (m_out_grey),
        .out_alpha     (m_out_alpha),
        .out_frame_end (m_out_frame_end)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks grey, alpha and frame_end of hidden_image_alpha_compose against a local
// prediction, using directed pixel pairs, a long output stall and random
// pixel streams under changing idle patterns on both channels
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned PIX_W        = hiac_pkg::PIX_W;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [PIX_W-1:0] above_blue;
        logic [PIX_W-1:0] above_green;
        logic [PIX_W-1:0] above_red;
        logic [PIX_W-1:0] under_blue;
        logic [PIX_W-1:0] under_green;
        logic [PIX_W-1:0] under_red;
        logic             frame_end;
    } pixel_pair_t;

    typedef struct packed {
        logic [PIX_W-1:0] grey;
        logic [PIX_W-1:0] alpha;
        logic             frame_end;
    } composite_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [PIX_W-1:0] s_above_blue;
    logic [PIX_W-1:0] s_above_green;
    logic [PIX_W-1:0] s_above_red;
    logic [PIX_W-1:0] s_under_blue;
    logic [PIX_W-1:0] s_under_green;
    logic [PIX_W-1:0] s_under_red;
    logic             s_frame_end;
    logic             m_valid;
    logic             m_ready;
    logic [PIX_W-1:0] m_out_grey;
    logic [PIX_W-1:0] m_out_alpha;
    logic             m_out_frame_end;

    composite_t  pending_composites[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned stall_len      = 0;
    int unsigned stall_req      = 0;
    int unsigned stall_seen     = 0;
    int unsigned stall_left     = 0;

    hidden_image_alpha_compose dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_above_blue    (s_above_blue),
        .s_above_green   (s_above_green),
        .s_above_red     (s_above_red),
        .s_under_blue    (s_under_blue),
        .s_under_green   (s_under_green),
        .s_under_red     (s_under_red),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_grey      (m_out_grey),
        .m_out_alpha     (m_out_alpha),
        .m_out_frame_end (m_out_frame_end)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // luma-like grey of one bgr pixel, at most 254
    function automatic int unsigned pixel_grey(input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] r);
        return int'(b) / 10 + (int'(g) * 6) / 10 + (int'(r) * 3) / 10;
    endfunction

    function automatic composite_t compose_pixel(input pixel_pair_t p);
        int unsigned lit;
        int unsigned dark;
        int unsigned opacity;
        composite_t  c;
        lit     = pixel_grey(p.above_blue, p.above_green, p.above_red) / 2 + 128;
        dark    = pixel_grey(p.under_blue, p.under_green, p.under_red) / 2;
        opacity = dark + 255 - lit;
        c.alpha     = opacity[PIX_W-1:0];
        c.grey      = (opacity == 0) ? '0 : PIX_W'((dark * 255) / opacity);
        c.frame_end = p.frame_end;
        return c;
    endfunction

    // channel value biased toward the extremes
    function automatic logic [PIX_W-1:0] random_channel(input int unsigned lo,
                                                        input int unsigned hi);
        int unsigned pick;
        pick = $urandom_range(7);
        if (pick == 0) return PIX_W'(lo);
        if (pick == 1) return PIX_W'(hi);
        return PIX_W'($urandom_range(hi, lo));
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        int unsigned a_lo;
        int unsigned a_hi;
        int unsigned u_hi;
        a_lo = 0;
        a_hi = 255;
        u_hi = 255;
        // bright surface over dark hidden pixel drives alpha toward zero
        if ($urandom_range(3) == 0) begin
            a_lo = 230;
            u_hi = 24;
        end
        p.above_blue  = random_channel(a_lo, a_hi);
        p.above_green = random_channel(a_lo, a_hi);
        p.above_red   = random_channel(a_lo, a_hi);
        p.under_blue  = random_channel(0, u_hi);
        p.under_green = random_channel(0, u_hi);
        p.under_red   = random_channel(0, u_hi);
        p.frame_end   = ($urandom_range(15) == 0);
        return p;
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_pair(input pixel_pair_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_above_blue  <= p.above_blue;
        s_above_green <= p.above_green;
        s_above_red   <= p.above_red;
        s_under_blue  <= p.under_blue;
        s_under_green <= p.under_green;
        s_under_red   <= p.under_red;
        s_frame_end   <= p.frame_end;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic pixel_pair_t make_pair(input logic [PIX_W-1:0] ab,
                                              input logic [PIX_W-1:0] ag,
                                              input logic [PIX_W-1:0] ar,
                                              input logic [PIX_W-1:0] ub,
                                              input logic [PIX_W-1:0] ug,
                                              input logic [PIX_W-1:0] ur,
                                              input logic fe);
        return '{ab, ag, ar, ub, ug, ur, fe};
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        // zero opacity: brightest surface over black
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd2, 8'd0, 1'b1));
        // alpha of one gives the largest grey
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd20, 8'd0, 8'd0, 1'b0));
        // widest opacity
        send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0));
        send_pair(make_pair(8'd9, 8'd1, 8'd3, 8'd10, 8'd2, 8'd4, 1'b0));
        send_pair(make_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1));
        send_pair(make_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        send_pair(make_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0));
        send_pair(make_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 1'b1));
        send_pair(make_pair(8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 1'b0));
    endtask

    // receiver holds off while the sender keeps offering transfers
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        s_valid <= 1'b0;
        @(negedge aclk);
        stall_len = 200;
        stall_req = stall_req + 1;
        @(posedge aclk);
        repeat (40) send_pair(random_pair());
    endtask

    task automatic test_random(input int unsigned count,
                               input int unsigned send_pct,
                               input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_pair(random_pair());
    endtask

    // result side: ready pattern and long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= stall_len;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // prediction on input transfers, comparison on output transfers
    always @(posedge aclk) begin
        composite_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_composites.size() == 0) begin
                $display("%0t: unexpected result grey %0d alpha %0d frame_end %0d",
                         $time, m_out_grey, m_out_alpha, m_out_frame_end);
                mismatch_count++;
            end else begin
                want = pending_composites.pop_front();
                if (m_out_grey !== want.grey) begin
                    $display("%0t: grey expected %0d actual %0d",
                             $time, want.grey, m_out_grey);
                    mismatch_count++;
                end
                if (m_out_alpha !== want.alpha) begin
                    $display("%0t: alpha expected %0d actual %0d",
                             $time, want.alpha, m_out_alpha);
                    mismatch_count++;
                end
                if (m_out_frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0d actual %0d",
                             $time, want.frame_end, m_out_frame_end);
                    mismatch_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            pending_composites.push_back(compose_pixel({s_above_blue, s_above_green,
                s_above_red, s_under_blue, s_under_green, s_under_red, s_frame_end}));
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_above_blue  <= '0;
        s_above_green <= '0;
        s_above_red   <= '0;
        s_under_blue  <= '0;
        s_under_green <= '0;
        s_under_red   <= '0;
        s_frame_end   <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_output_stall();
        test_random(330, 31, 82);
        test_random(330, 82, 31);
        test_random(340, 0, 0);

        s_valid <= 1'b0;
        while (pending_composites.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
design/hiac_pkg.sv
design/hiac_front.sv
design/hiac_queue.sv
design/hiac_back.sv
design/hidden_image_alpha_compose.sv
verif/tb.sv
